// File: src/led_blink_controller_unit_macros.svh
// Assertion macros shared by the LED blink controller RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LED_BLINK_CONTROLLER_UNIT_MACROS_SVH
`define LED_BLINK_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("LED blink controller check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("LED blink controller check failed");

`endif

// File: src/lbc_pkg.sv
// Package for the LED blink controller: sizes, command codes, configuration
// record and the period selection functions. Depends on nothing.
`default_nettype none

package lbc_pkg;

    localparam int NUM_LEDS     = 8;
    localparam int NUM_CHANNELS = 4;
    localparam int COUNT_WIDTH  = 16;
    localparam int CH_USED      = (NUM_CHANNELS < NUM_LEDS) ? NUM_CHANNELS : NUM_LEDS;

    localparam int CMD_W       = 3;
    localparam int IDX_W       = 4;
    localparam int SPD_W       = 3;
    localparam int LED_W       = 8;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [IDX_W-1:0] ALL_INDEX = IDX_W'(NUM_LEDS);
    localparam logic [IDX_W-1:0] CH_LIMIT  = IDX_W'(CH_USED);

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [1:0]             t_speed;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_ON     = 3'd1,
        CMD_OFF    = 3'd2,
        CMD_TOGGLE = 3'd3,
        CMD_BLINK  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        SPD_SINGLE = 2'd0,
        SPD_SLOW   = 2'd1,
        SPD_NORMAL = 2'd2,
        SPD_FAST   = 2'd3
    } t_speed_code;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SINGLE_ON    = 3'd0,
        REG_SLOW_TOTAL   = 3'd1,
        REG_SLOW_ON      = 3'd2,
        REG_NORMAL_TOTAL = 3'd3,
        REG_NORMAL_ON    = 3'd4,
        REG_FAST_TOTAL   = 3'd5,
        REG_FAST_ON      = 3'd6
    } t_reg_addr;

    typedef struct packed {
        logic [CFG_W-1:0] single_on;
        logic [CFG_W-1:0] slow_total;
        logic [CFG_W-1:0] slow_on;
        logic [CFG_W-1:0] normal_total;
        logic [CFG_W-1:0] normal_on;
        logic [CFG_W-1:0] fast_total;
        logic [CFG_W-1:0] fast_on;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        single_on:    16'd200,
        slow_total:   16'd5000,
        slow_on:      16'd200,
        normal_total: 16'd1000,
        normal_on:    16'd200,
        fast_total:   16'd200,
        fast_on:      16'd100
    };

    function automatic t_count start_period(input t_cfg cfg, input t_speed speed);
        logic [CFG_W-1:0] v;
        case (t_speed_code'(speed))
            SPD_SINGLE: v = cfg.single_on;
            SPD_SLOW:   v = cfg.slow_on;
            SPD_NORMAL: v = cfg.normal_on;
            default:    v = cfg.fast_on;
        endcase
        return t_count'(v);
    endfunction

    function automatic t_count reload_period(input t_cfg cfg, input t_speed speed,
                                             input logic led_on);
        logic [CFG_W-1:0] v;
        case (t_speed_code'(speed))
            SPD_SLOW:   v = led_on ? cfg.slow_on : cfg.slow_total;
            SPD_NORMAL: v = led_on ? cfg.normal_on : cfg.normal_total;
            default:    v = led_on ? cfg.fast_on : cfg.fast_total;
        endcase
        return t_count'(v);
    endfunction

endpackage

`default_nettype wire

// File: src/led_blink_controller_unit.sv
// LED blink controller: one command beat in, one pattern and status beat out.
// Output beats are registered; one beat per cycle is sustained while the output is ready.
// The state and the output register are updated at the edge that takes a beat; input is
// held off only while a result waits and the output side is not ready.
// Synchronous active-low reset clears the pattern, the channels and the output valid
// and loads the default blink periods. Depends on lbc_pkg and the macros header.
`default_nettype none

`include "led_blink_controller_unit_macros.svh"

module led_blink_controller_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // cmd [2:0], led_index [6:3], rate_sel [9:7], zero [15:10]
    input  wire logic [lbc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // led_pattern [7:0], status [8], zero [15:9]
    output logic [lbc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                              i_cfg_we,
    input  wire logic [lbc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [lbc_pkg::CFG_W-1:0]        i_cfg_wdata
);

    lbc_pkg::t_cfg                      r_cfg;
    logic [lbc_pkg::NUM_LEDS-1:0]       r_pattern;
    logic [lbc_pkg::NUM_LEDS-1:0]       n_pattern;
    logic [lbc_pkg::CH_USED-1:0]        r_run;
    logic [lbc_pkg::CH_USED-1:0]        n_run;
    lbc_pkg::t_speed                    r_speed [lbc_pkg::CH_USED];
    lbc_pkg::t_speed                    n_speed [lbc_pkg::CH_USED];
    lbc_pkg::t_count                    r_cnt   [lbc_pkg::CH_USED];
    lbc_pkg::t_count                    n_cnt   [lbc_pkg::CH_USED];
    logic                               r_m_valid;
    logic [lbc_pkg::LED_W-1:0]          r_m_pattern;
    logic                               r_m_status;
    logic                               n_status;
    logic                               s_acc;
    lbc_pkg::t_cmd                      in_cmd;
    logic [lbc_pkg::IDX_W-1:0]          in_led;
    logic [lbc_pkg::SPD_W-1:0]          in_speed;
    logic                               in_all;
    logic [lbc_pkg::NUM_LEDS-1:0]       in_mask;

    assign in_cmd   = lbc_pkg::t_cmd'(s_axis_tdata[2:0]);
    assign in_led   = s_axis_tdata[6:3];
    assign in_speed = s_axis_tdata[9:7];
    assign in_all   = (in_led == lbc_pkg::ALL_INDEX);
    assign in_mask  = in_all ? {lbc_pkg::NUM_LEDS{1'b1}}
                             : (lbc_pkg::NUM_LEDS'(1) << in_led);

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_pattern = r_pattern;
        n_run     = r_run;
        n_speed   = r_speed;
        n_cnt     = r_cnt;
        n_status  = 1'b0;
        if (in_cmd == lbc_pkg::CMD_TICK) begin
            for (int ch = 0; ch < lbc_pkg::CH_USED; ch++) begin
                if (r_run[ch]) begin
                    if (r_cnt[ch] > lbc_pkg::t_count'(1)) begin
                        n_cnt[ch] = r_cnt[ch] - lbc_pkg::t_count'(1);
                    end else begin
                        n_pattern[ch] = ~r_pattern[ch];
                        if (r_speed[ch] == lbc_pkg::SPD_SINGLE) begin
                            n_run[ch] = 1'b0;
                            n_cnt[ch] = '0;
                        end else begin
                            n_cnt[ch] = lbc_pkg::reload_period(r_cfg, r_speed[ch],
                                                               ~r_pattern[ch]);
                        end
                    end
                end
            end
        end else if (in_led > lbc_pkg::ALL_INDEX) begin
            n_status = 1'b1;
        end else begin
            case (in_cmd)
                lbc_pkg::CMD_ON: begin
                    n_pattern = r_pattern | in_mask;
                end
                lbc_pkg::CMD_OFF: begin
                    n_pattern = r_pattern & ~in_mask;
                    for (int ch = 0; ch < lbc_pkg::CH_USED; ch++) begin
                        if (in_all || in_led == lbc_pkg::IDX_W'(ch)) begin
                            n_run[ch] = 1'b0;
                            n_cnt[ch] = '0;
                        end
                    end
                end
                lbc_pkg::CMD_TOGGLE: begin
                    n_pattern = r_pattern ^ in_mask;
                end
                lbc_pkg::CMD_BLINK: begin
                    if ((!in_all && in_led >= lbc_pkg::CH_LIMIT) || in_speed[2]) begin
                        n_status = 1'b1;
                    end else begin
                        n_pattern = r_pattern ^ in_mask;
                        for (int ch = 0; ch < lbc_pkg::CH_USED; ch++) begin
                            if (in_all || in_led == lbc_pkg::IDX_W'(ch)) begin
                                n_run[ch]   = 1'b1;
                                n_speed[ch] = in_speed[1:0];
                                n_cnt[ch]   = lbc_pkg::start_period(r_cfg, in_speed[1:0]);
                            end
                        end
                    end
                end
                default: begin
                    n_status = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= lbc_pkg::CFG_RESET;
            r_pattern <= '0;
            r_run     <= '0;
            r_m_valid <= 1'b0;
            for (int ch = 0; ch < lbc_pkg::CH_USED; ch++) begin
                r_speed[ch] <= '0;
                r_cnt[ch]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (lbc_pkg::t_reg_addr'(i_cfg_addr))
                    lbc_pkg::REG_SINGLE_ON:    r_cfg.single_on    <= i_cfg_wdata;
                    lbc_pkg::REG_SLOW_TOTAL:   r_cfg.slow_total   <= i_cfg_wdata;
                    lbc_pkg::REG_SLOW_ON:      r_cfg.slow_on      <= i_cfg_wdata;
                    lbc_pkg::REG_NORMAL_TOTAL: r_cfg.normal_total <= i_cfg_wdata;
                    lbc_pkg::REG_NORMAL_ON:    r_cfg.normal_on    <= i_cfg_wdata;
                    lbc_pkg::REG_FAST_TOTAL:   r_cfg.fast_total   <= i_cfg_wdata;
                    lbc_pkg::REG_FAST_ON:      r_cfg.fast_on      <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s_acc) begin
                r_pattern <= n_pattern;
                r_run     <= n_run;
                r_speed   <= n_speed;
                r_cnt     <= n_cnt;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_m_pattern <= lbc_pkg::LED_W'(n_pattern);
            r_m_status  <= n_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(lbc_pkg::OUT_TDATA_W - lbc_pkg::LED_W - 1){1'b0}},
                            r_m_status, r_m_pattern};

    `LBC_ASSERT_NOW(a_ready_only_blocked_by_output, i_clk, i_rst_n,
                    !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    `LBC_ASSERT_NEXT(a_beat_gives_result, i_clk, i_rst_n,
                     s_acc, m_axis_tvalid)
    `LBC_ASSERT_NEXT(a_invalid_keeps_pattern, i_clk, i_rst_n,
                     s_acc && n_status, $stable(r_pattern) && r_m_status)

    for (genvar g = 0; g < lbc_pkg::CH_USED; g++) begin : g_chk
        `LBC_ASSERT_NOW(a_idle_channel_clear, i_clk, i_rst_n,
                        !r_run[g], r_cnt[g] == '0)
    end

endmodule

`default_nettype wire
